// File: sv/fsls_pkg.sv
// Package for the step-size search controller: fixed field widths,
// register indexes and the sequencer and search phase encodings.
// No dependencies.
`default_nettype none
package fsls_pkg;
	localparam int RF_W       = 32; // reduction factor, Q0.32
	localparam int AMIN_W     = 32; // alpha minimum, Q0.32
	localparam int SLACK_W    = 24; // slack factor, Q8.16
	localparam int SLACK_FRAC = 16;
	localparam int LIM_W      = 8;  // loop limit registers
	localparam int EVAL_W     = 10;
	localparam int RED_W      = 9;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLACK     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REDUCTION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RED   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BIS   = 3'd5;

	typedef enum logic [5:0] {
		PH_IDLE     = 6'b000001,
		PH_START    = 6'b000010,
		PH_FULL     = 6'b000100,
		PH_BRACKET  = 6'b001000,
		PH_FALLBACK = 6'b010000,
		PH_BISECT   = 6'b100000
	} phase_t;

	typedef enum logic [15:0] {
		ST_IDLE     = 16'h0001,
		ST_TGT_W    = 16'h0002,
		ST_DISPATCH = 16'h0004,
		ST_BCHK     = 16'h0008,
		ST_BNEXT    = 16'h0010,
		ST_RFM_W    = 16'h0020,
		ST_RFD_W    = 16'h0040,
		ST_RF_PICK  = 16'h0080,
		ST_SCL_W    = 16'h0100,
		ST_ABR      = 16'h0200,
		ST_FNEXT    = 16'h0400,
		ST_BT_W     = 16'h0800,
		ST_UP_W     = 16'h1000,
		ST_DECIDE   = 16'h2000,
		ST_BISNEXT  = 16'h4000,
		ST_EMIT     = 16'h8000
	} seq_state_t;
endpackage
`default_nettype wire

// File: sv/feasible_step_line_search.sv
// Step-size search controller top level: sequencer, search state and one
// shared shift-add multiplier / restoring divider.
// Depends on fsls_pkg.
`default_nettype none
// A start transaction (cmd 0) answers with a request to evaluate alpha 0.
// Each reply transaction (cmd 1) carries the distance at the alpha last
// requested and yields one result transaction: the next alpha to evaluate
// (kind 0) or the final result (kind 1). Replies while idle are dropped.
// The search runs full-step check, safeguarded regula falsi bracketing,
// geometric backtracking, then bisection. All multiplies and divides go
// through one serial unit doing one bit per cycle. Every reply first forms
// the target distance with a ML-step multiply (ML = max(ALPHA_FRAC_BITS+1,
// 32), 33 at default); a regula falsi step adds a multiply, an
// ALPHA_FRAC_BITS+1 step divide and a safeguard multiply; a backtracking
// step adds one multiply, and a fallback exit adds a 32-step divide. The
// input is stalled while a transaction is being worked on; a finished
// result waits in a holding register when the output is stalled.
module feasible_step_line_search #(
	parameter int ALPHA_FRAC_BITS = 32,
	parameter int DIST_BITS       = 48,
	parameter int STEP_COUNT_BITS = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [fsls_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [((DIST_BITS > 32) ? DIST_BITS : 32)-1:0] cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic                                   cmd,
	input  wire logic [DIST_BITS-1:0]                   distance,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        kind,
	output logic [ALPHA_FRAC_BITS:0]                    alpha,
	output logic [DIST_BITS-1:0]                        min_distance,
	output logic                                        feasible,
	output logic                                        collision_free,
	output logic                                        had_failure,
	output logic                                        step_clipped,
	output logic [fsls_pkg::EVAL_W-1:0]                 evaluations,
	output logic [fsls_pkg::RED_W-1:0]                  reductions
);
	import fsls_pkg::*;

	localparam int AW   = ALPHA_FRAC_BITS + 1;     // alpha incl. the 1.0 bit
	localparam int DW   = DIST_BITS;
	localparam int PHW  = DIST_BITS + 1;           // signed phi
	localparam int RW   = DIST_BITS + 2;           // divider remainder
	localparam int PW   = AW + PHW;                // product / accumulator
	localparam int ML   = (AW > RF_W) ? AW : RF_W; // multiplier bits
	localparam int CMPW = ML;
	localparam int CNTW = $clog2(ML + 1);
	localparam int SW   = STEP_COUNT_BITS;
	localparam int LIMW = (SW > LIM_W) ? SW : LIM_W;

	localparam logic [AW-1:0] ONE  = AW'(1) << ALPHA_FRAC_BITS;
	localparam logic [DW-1:0] DMAX = {DW{1'b1}};
	localparam logic [SW-1:0] SMAX = {SW{1'b1}};

	// configuration
	logic [DW-1:0]      tol_q;
	logic [SLACK_W-1:0] slack_q;
	logic [RF_W-1:0]    rf_q;
	logic [AMIN_W-1:0]  amin_q;
	logic [LIM_W-1:0]   maxr_q, maxb_q;

	// sequencer and search state
	seq_state_t          state_q;
	phase_t              phase_q;
	logic [DW-1:0]       d_q, t_q;
	logic [AW-1:0]       low_q, high_q, pending_q, bt_q, a_q;
	logic signed [PHW-1:0] low_phi_q, high_phi_q;
	logic [DW-1:0]       low_dist_q, high_dist_q, start_dist_q, full_dist_q;
	logic [SW-1:0]       loop_q;
	logic [EVAL_W-1:0]   eval_q;
	logic [RED_W-1:0]    red_q;
	logic                clip_q, bracket_q;

	// result holding register
	logic                res_kind_q, res_feas_q, res_cf_q, res_fail_q;
	logic [AW-1:0]       res_alpha_q;
	logic [DW-1:0]       res_dist_q;

	// output register
	logic                out_valid_q;
	logic                emit_go;

	// shared arithmetic unit
	logic [PW-1:0]       acc_q, aux_q;
	logic [ML-1:0]       mlr_q;
	logic [CNTW-1:0]     cnt_q;
	logic                div_q;
	logic                u_busy;

	logic                ld_go, ld_div;
	logic [PW-1:0]       ld_acc, ld_aux;
	logic [ML-1:0]       ld_lo;
	logic [CNTW-1:0]     ld_steps;

	function automatic logic signed [PHW-1:0] phi_f(input logic [DW-1:0] dd,
	                                                input logic [DW-1:0] tt);
		return $signed({1'b0, dd}) - $signed({1'b0, tt});
	endfunction

	function automatic logic [SW-1:0] lim_f(input logic [LIM_W-1:0] r);
		logic [LIMW-1:0] e;
		e = LIMW'(r);
		return (e > LIMW'(SMAX)) ? SMAX : e[SW-1:0];
	endfunction

	logic                  in_fire;
	logic [AW-1:0]         width, mid, q_res, scl_res, lower, upper, clamp_a;
	logic [AW:0]           mid_sum;
	logic                  wid_le_min, sign_chg, d_ge_t, rf_le_pend, bnext_go, in_bracket;
	logic [SW-1:0]         lim_r, lim_b;
	logic signed [PHW-1:0] p_w;
	logic [PHW-1:0]        den;
	logic [DW-1:0]         tgt;
	logic [RW-1:0]         dv_t;
	logic                  dv_ge;

	assign in_fire    = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign u_busy     = (cnt_q != '0);
	assign width      = high_q - low_q;
	assign mid_sum    = {1'b0, low_q} + {1'b0, high_q};
	assign mid        = mid_sum[AW:1];
	assign wid_le_min = CMPW'(width) <= CMPW'(amin_q);
	assign lim_r      = lim_f(maxr_q);
	assign lim_b      = lim_f(maxb_q);
	assign p_w        = phi_f(d_q, t_q);
	assign d_ge_t     = (d_q >= t_q);
	assign sign_chg   = !low_phi_q[PHW-1] && (low_phi_q != '0) && high_phi_q[PHW-1];
	assign den        = PHW'(low_phi_q - high_phi_q);
	assign rf_le_pend = CMPW'(pending_q) >= CMPW'(rf_q);
	assign bnext_go   = !((loop_q >= lim_r) || wid_le_min);
	assign in_bracket = (a_q > low_q) && (a_q < high_q);
	assign q_res      = mlr_q[AW-1:0];
	assign scl_res    = acc_q[RF_W+AW-1:RF_W];
	assign lower      = low_q + scl_res;
	assign upper      = high_q - scl_res;
	assign tgt        = (|acc_q[PW-1:SLACK_FRAC+DW]) ? DMAX : acc_q[SLACK_FRAC+DW-1:SLACK_FRAC];
	assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		clamp_a = a_q;
		if (clamp_a > upper) clamp_a = upper;
		if (clamp_a < lower) clamp_a = lower;
	end

	// unit launches
	always_comb begin
		ld_go    = 1'b0;
		ld_div   = 1'b0;
		ld_acc   = '0;
		ld_aux   = '0;
		ld_lo    = '0;
		ld_steps = CNTW'(ML);
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && cmd && (phase_q != PH_IDLE)) begin
					ld_go  = 1'b1;
					ld_aux = PW'(tol_q);
					ld_lo  = ML'(slack_q);
				end
			end
			ST_DISPATCH: begin
				if ((phase_q == PH_FALLBACK) && d_ge_t && !rf_le_pend) begin
					ld_go    = 1'b1;
					ld_div   = 1'b1;
					ld_acc   = PW'(pending_q);
					ld_aux   = PW'(rf_q);
					ld_steps = CNTW'(RF_W);
				end
			end
			ST_BNEXT: begin
				if (bnext_go && sign_chg) begin
					ld_go  = 1'b1;
					ld_aux = PW'(low_phi_q);
					ld_lo  = ML'(width);
				end
			end
			ST_RFM_W: begin
				if (!u_busy) begin
					ld_go    = 1'b1;
					ld_div   = 1'b1;
					ld_acc   = PW'(acc_q[PW-1:AW]);
					ld_lo    = ML'(acc_q[AW-1:0]);
					ld_aux   = PW'(den);
					ld_steps = CNTW'(AW);
				end
			end
			ST_RF_PICK: begin
				if (in_bracket) begin
					ld_go  = 1'b1;
					ld_aux = PW'(width);
					ld_lo  = ML'(rf_q);
				end
			end
			ST_FNEXT: begin
				if (loop_q < lim_r) begin
					ld_go  = 1'b1;
					ld_aux = PW'(bt_q);
					ld_lo  = ML'(rf_q);
				end
			end
			default: ;
		endcase
	end

	// shared unit: shift-add multiply, restoring divide, one bit a cycle
	assign dv_t  = {acc_q[RW-2:0], mlr_q[AW-1]};
	assign dv_ge = (dv_t >= aux_q[RW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			aux_q <= '0;
			mlr_q <= '0;
			div_q <= 1'b0;
			cnt_q <= '0;
		end else if (ld_go) begin
			acc_q <= ld_acc;
			aux_q <= ld_aux;
			mlr_q <= ld_lo;
			div_q <= ld_div;
			cnt_q <= ld_steps;
		end else if (u_busy) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (div_q) begin
				acc_q <= PW'(dv_ge ? (dv_t - aux_q[RW-1:0]) : dv_t);
				mlr_q <= {mlr_q[ML-2:0], dv_ge};
			end else begin
				if (mlr_q[0]) acc_q <= acc_q + aux_q;
				aux_q <= aux_q << 1;
				mlr_q <= mlr_q >> 1;
			end
		end
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= DW'(42949673);
			slack_q <= SLACK_W'(65536);
			rf_q    <= 32'h8000_0000;
			amin_q  <= AMIN_W'(4295);
			maxr_q  <= LIM_W'(20);
			maxb_q  <= LIM_W'(20);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOLERANCE: tol_q   <= cfg_data[DW-1:0];
				CFG_SLACK:     slack_q <= cfg_data[SLACK_W-1:0];
				CFG_REDUCTION: rf_q    <= cfg_data[RF_W-1:0];
				CFG_ALPHA_MIN: amin_q  <= cfg_data[AMIN_W-1:0];
				CFG_MAX_RED:   maxr_q  <= cfg_data[LIM_W-1:0];
				CFG_MAX_BIS:   maxb_q  <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// output valid: set when a result is loaded, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= PH_IDLE;
			d_q            <= '0;
			t_q            <= '0;
			low_q          <= '0;
			high_q         <= ONE;
			pending_q      <= '0;
			bt_q           <= ONE;
			a_q            <= '0;
			low_phi_q      <= '0;
			high_phi_q     <= '0;
			low_dist_q     <= '0;
			high_dist_q    <= '0;
			start_dist_q   <= '0;
			full_dist_q    <= '0;
			loop_q         <= '0;
			eval_q         <= '0;
			red_q          <= '0;
			clip_q         <= 1'b0;
			bracket_q      <= 1'b1;
			res_kind_q     <= 1'b0;
			res_feas_q     <= 1'b0;
			res_cf_q       <= 1'b0;
			res_fail_q     <= 1'b0;
			res_alpha_q    <= '0;
			res_dist_q     <= '0;
			kind           <= 1'b0;
			alpha          <= '0;
			min_distance   <= '0;
			feasible       <= 1'b0;
			collision_free <= 1'b0;
			had_failure    <= 1'b0;
			step_clipped   <= 1'b0;
			evaluations    <= '0;
			reductions     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						d_q <= distance;
						if (!cmd) begin
							low_q       <= '0;
							high_q      <= ONE;
							low_phi_q   <= '0;
							high_phi_q  <= '0;
							low_dist_q  <= '0;
							high_dist_q <= '0;
							start_dist_q <= '0;
							full_dist_q <= '0;
							bt_q        <= ONE;
							loop_q      <= '0;
							eval_q      <= '0;
							red_q       <= '0;
							clip_q      <= 1'b0;
							bracket_q   <= 1'b1;
							pending_q   <= '0;
							phase_q     <= PH_START;
							res_kind_q  <= 1'b0;
							res_alpha_q <= '0;
							state_q     <= ST_EMIT;
						end else if (phase_q != PH_IDLE) begin
							state_q <= ST_TGT_W;
						end
					end
				end
				ST_TGT_W: begin
					if (!u_busy) begin
						t_q     <= tgt;
						eval_q  <= eval_q + EVAL_W'(1);
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					unique case (phase_q)
						PH_START: begin
							start_dist_q <= d_q;
							if (!d_ge_t) begin
								phase_q     <= PH_IDLE;
								res_kind_q  <= 1'b1;
								res_alpha_q <= '0;
								res_dist_q  <= d_q;
								res_feas_q  <= 1'b0;
								res_cf_q    <= 1'b0;
								res_fail_q  <= 1'b1;
							end else begin
								pending_q   <= ONE;
								phase_q     <= PH_FULL;
								res_kind_q  <= 1'b0;
								res_alpha_q <= ONE;
							end
							state_q <= ST_EMIT;
						end
						PH_FULL: begin
							full_dist_q <= d_q;
							if (d_ge_t) begin
								phase_q     <= PH_IDLE;
								res_kind_q  <= 1'b1;
								res_alpha_q <= ONE;
								res_dist_q  <= d_q;
								res_feas_q  <= 1'b1;
								res_cf_q    <= 1'b1;
								res_fail_q  <= 1'b0;
								state_q     <= ST_EMIT;
							end else begin
								clip_q      <= 1'b1;
								low_q       <= '0;
								low_dist_q  <= start_dist_q;
								low_phi_q   <= phi_f(start_dist_q, t_q);
								high_q      <= ONE;
								high_dist_q <= d_q;
								high_phi_q  <= p_w;
								bracket_q   <= 1'b1;
								loop_q      <= '0;
								state_q     <= ST_BNEXT;
							end
						end
						PH_BRACKET: begin
							if (!p_w[PHW-1]) begin
								low_q      <= pending_q;
								low_dist_q <= d_q;
								low_phi_q  <= p_w;
							end else begin
								high_q      <= pending_q;
								high_dist_q <= d_q;
								high_phi_q  <= p_w;
								red_q       <= red_q + RED_W'(1);
							end
							state_q <= ST_BCHK;
						end
						PH_FALLBACK: begin
							if (d_ge_t) begin
								low_q      <= pending_q;
								low_dist_q <= d_q;
								low_phi_q  <= p_w;
								bracket_q  <= 1'b1;
								if (rf_le_pend) begin
									// rebuilt upper bound reaches 1.0
									high_q      <= ONE;
									high_dist_q <= full_dist_q;
									high_phi_q  <= phi_f(full_dist_q, t_q);
									state_q     <= ST_DECIDE;
								end else begin
									state_q <= ST_UP_W;
								end
							end else begin
								if (loop_q != SMAX) loop_q <= loop_q + SW'(1);
								state_q <= ST_FNEXT;
							end
						end
						PH_BISECT: begin
							if (d_ge_t) begin
								low_q      <= pending_q;
								low_dist_q <= d_q;
								low_phi_q  <= p_w;
							end else begin
								high_q      <= pending_q;
								high_dist_q <= d_q;
								high_phi_q  <= p_w;
							end
							if (loop_q != SMAX) loop_q <= loop_q + SW'(1);
							state_q <= ST_BISNEXT;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_BCHK: begin
					if (wid_le_min) begin
						bracket_q <= 1'b1;
						state_q   <= ST_ABR;
					end else if (high_phi_q == low_phi_q) begin
						state_q <= ST_ABR;
					end else begin
						if (loop_q != SMAX) loop_q <= loop_q + SW'(1);
						state_q <= ST_BNEXT;
					end
				end
				ST_BNEXT: begin
					if (!bnext_go) begin
						state_q <= ST_ABR;
					end else if (sign_chg) begin
						state_q <= ST_RFM_W;
					end else begin
						a_q     <= low_q; // degenerate, falls to midpoint
						state_q <= ST_RF_PICK;
					end
				end
				ST_RFM_W: begin
					if (!u_busy) state_q <= ST_RFD_W;
				end
				ST_RFD_W: begin
					if (!u_busy) begin
						a_q     <= low_q + q_res;
						state_q <= ST_RF_PICK;
					end
				end
				ST_RF_PICK: begin
					if (!in_bracket) begin
						pending_q   <= mid;
						phase_q     <= PH_BRACKET;
						res_kind_q  <= 1'b0;
						res_alpha_q <= mid;
						state_q     <= ST_EMIT;
					end else begin
						state_q <= ST_SCL_W;
					end
				end
				ST_SCL_W: begin
					if (!u_busy) begin
						pending_q   <= clamp_a;
						phase_q     <= PH_BRACKET;
						res_kind_q  <= 1'b0;
						res_alpha_q <= clamp_a;
						state_q     <= ST_EMIT;
					end
				end
				ST_ABR: begin
					if (low_q == '0) begin
						bt_q    <= ONE;
						loop_q  <= '0;
						state_q <= ST_FNEXT;
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_FNEXT: begin
					if (loop_q >= lim_r) state_q <= ST_DECIDE;
					else state_q <= ST_BT_W;
				end
				ST_BT_W: begin
					if (!u_busy) begin
						bt_q  <= scl_res;
						red_q <= red_q + RED_W'(1);
						if (CMPW'(scl_res) < CMPW'(amin_q)) begin
							bracket_q <= 1'b0;
							state_q   <= ST_DECIDE;
						end else begin
							pending_q   <= scl_res;
							phase_q     <= PH_FALLBACK;
							res_kind_q  <= 1'b0;
							res_alpha_q <= scl_res;
							state_q     <= ST_EMIT;
						end
					end
				end
				ST_UP_W: begin
					if (!u_busy) begin
						high_q     <= q_res;
						high_phi_q <= phi_f(high_dist_q, t_q);
						state_q    <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!bracket_q || (low_q == '0)) begin
						// search failed
						phase_q     <= PH_IDLE;
						res_kind_q  <= 1'b1;
						res_alpha_q <= '0;
						res_dist_q  <= start_dist_q;
						res_feas_q  <= 1'b0;
						res_cf_q    <= 1'b1;
						res_fail_q  <= 1'b1;
						state_q     <= ST_EMIT;
					end else begin
						loop_q  <= '0;
						state_q <= ST_BISNEXT;
					end
				end
				ST_BISNEXT: begin
					if ((loop_q < lim_b) && !wid_le_min && (mid > low_q) && (mid < high_q)) begin
						pending_q   <= mid;
						phase_q     <= PH_BISECT;
						res_kind_q  <= 1'b0;
						res_alpha_q <= mid;
					end else begin
						phase_q     <= PH_IDLE;
						res_kind_q  <= 1'b1;
						res_alpha_q <= low_q;
						res_dist_q  <= low_dist_q;
						res_feas_q  <= 1'b1;
						res_cf_q    <= 1'b1;
						res_fail_q  <= 1'b0;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						kind        <= res_kind_q;
						alpha       <= res_alpha_q;
						if (res_kind_q) begin
							min_distance   <= res_dist_q;
							feasible       <= res_feas_q;
							collision_free <= res_cf_q;
							had_failure    <= res_fail_q;
							step_clipped   <= clip_q;
							evaluations    <= eval_q;
							reductions     <= red_q;
						end else begin
							min_distance   <= '0;
							feasible       <= 1'b0;
							collision_free <= 1'b0;
							had_failure    <= 1'b0;
							step_clipped   <= 1'b0;
							evaluations    <= '0;
							reductions     <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire
